// ----- rtl/dga_pkg.sv -----
// Shared types and constants for the daily group averager.
// No dependencies; the RTL files that use it refer to it by scoped names.
`default_nettype none

package dga_pkg;

  localparam int CHANNELS = 4;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int VAL_W   = 18;
  localparam int SUM_W   = 27;
  localparam int BAND_W  = 10;

  // APB register file: one register, word addressed by paddr[ADDR_W-1:2]
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_ZERO_BAND = 1'b0;
  localparam logic [BAND_W-1:0] ZERO_BAND_RESET = 10'd1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // closed group as handed from front to back (counts travel beside it)
  typedef struct packed {
    date_t                 date;
    sum_t [CHANNELS-1:0]   sum;
    logic                  last;
  } group_t;

  localparam sum_t SUM_MAX = sum_t'(2 ** (SUM_W - 1) - 1);
  localparam sum_t SUM_MIN = sum_t'(-(2 ** (SUM_W - 1)));
  localparam val_t MEAN_MAX = val_t'(2 ** (VAL_W - 1) - 1);
  localparam val_t MEAN_MIN = val_t'(-(2 ** (VAL_W - 1)));

  // quotient magnitude limits before saturation
  localparam logic [SUM_W-1:0] MEAN_POS_LIM = SUM_W'(2 ** (VAL_W - 1) - 1);
  localparam logic [SUM_W-1:0] MEAN_NEG_LIM = SUM_W'(2 ** (VAL_W - 1));

endpackage

`default_nettype wire

// ----- rtl/dga_in_if.sv -----
// Input channel of the daily group averager: one dated reading per item.
// Depends on dga_pkg for field widths.
`default_nettype none

interface dga_in_if;
  logic                              valid;
  logic                              ready;
  logic [dga_pkg::YEAR_W-1:0]        year;
  logic [dga_pkg::MONTH_W-1:0]       month;
  logic [dga_pkg::DAY_W-1:0]         day_of_month;
  logic signed [dga_pkg::VAL_W-1:0]  value_0;
  logic signed [dga_pkg::VAL_W-1:0]  value_1;
  logic signed [dga_pkg::VAL_W-1:0]  value_2;
  logic signed [dga_pkg::VAL_W-1:0]  value_3;
  logic                              end_of_data;

  modport source (
    output valid, year, month, day_of_month, value_0, value_1, value_2, value_3,
           end_of_data,
    input  ready
  );
  modport sink (
    input  valid, year, month, day_of_month, value_0, value_1, value_2, value_3,
           end_of_data,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/dga_out_if.sv -----
// Output channel of the daily group averager: one daily mean record per item.
// Depends on dga_pkg for field widths.
`default_nettype none

interface dga_out_if;
  logic                              valid;
  logic                              ready;
  logic [dga_pkg::YEAR_W-1:0]        out_year;
  logic [dga_pkg::MONTH_W-1:0]       out_month;
  logic [dga_pkg::DAY_W-1:0]         out_day;
  logic signed [dga_pkg::VAL_W-1:0]  mean_0;
  logic signed [dga_pkg::VAL_W-1:0]  mean_1;
  logic signed [dga_pkg::VAL_W-1:0]  mean_2;
  logic signed [dga_pkg::VAL_W-1:0]  mean_3;
  logic                              last_of_run;

  modport source (
    output valid, out_year, out_month, out_day, mean_0, mean_1, mean_2, mean_3,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_year, out_month, out_day, mean_0, mean_1, mean_2, mean_3,
           last_of_run,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/dga_fifo.sv -----
// Small register FIFO carrying closed groups from the front to the back.
// Generic width and depth; no package dependency.
`default_nettype none

module dga_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dga_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependency.
`default_nettype none

module dga_div #(
  parameter int NW = 27,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int STEP_W = $clog2(NW + 1);

  logic [DW-1:0]     rem;
  logic [NW-1:0]     quo;
  logic [DW-1:0]     dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DW:0]       rem_sh;
  logic              ge;

  // dividend bits shift out of quo's top while quotient bits shift in below
  assign rem_sh   = {rem, quo[NW-1]};
  assign ge       = (rem_sh >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
        steps <= STEP_W'(NW);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
        quo   <= {quo[NW-2:0], ge};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dga_front.sv -----
// Front end: accepts readings, detects date changes, keeps per-channel sums
// and counts, and pushes closed groups into the FIFO. Uses dga_pkg, dga_in_if.
`default_nettype none

module dga_front #(
  parameter int MAX_READINGS_PER_DAY = 256,
  parameter int CNT_W                = 9
) (
  input  logic                                      clk,
  input  logic                                      rst,
  dga_in_if.sink                                    rd,
  input  logic [dga_pkg::BAND_W-1:0]                zero_band,
  input  logic                                      q_full,
  output logic                                      q_push,
  output dga_pkg::group_t                           push_grp,
  output logic [dga_pkg::CHANNELS-1:0][CNT_W-1:0]   push_cnt
);

  localparam int C  = dga_pkg::CHANNELS;
  localparam int VW = dga_pkg::VAL_W;
  localparam int SW = dga_pkg::SUM_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_READINGS_PER_DAY);

  logic                       open;
  logic                       pend;   // end of data seen, group flush still owed
  dga_pkg::date_t             gdate;
  dga_pkg::date_t             in_date;
  dga_pkg::sum_t [C-1:0]      sum;
  dga_pkg::sum_t [C-1:0]      sum_next;
  logic [C-1:0][CNT_W-1:0]    cnt;
  logic [C-1:0][CNT_W-1:0]    cnt_next;
  logic [C-1:0][VW-1:0]       in_val;
  logic                       accept;
  logic                       change;

  assign in_date   = {rd.year, rd.month, rd.day_of_month};
  assign in_val[0] = rd.value_0;
  assign in_val[1] = rd.value_1;
  assign in_val[2] = rd.value_2;
  assign in_val[3] = rd.value_3;

  assign rd.ready = !pend && !q_full;
  assign accept   = rd.valid && rd.ready;
  assign change   = open && (in_date != gdate);

  always_comb begin
    logic [SW:0]      s_wide;
    logic [VW:0]      mag;
    logic [SW-1:0]    base_s;
    logic [CNT_W-1:0] base_n;
    logic             counted;
    for (int c = 0; c < C; c++) begin
      base_s = change ? '0 : sum[c];
      base_n = change ? '0 : cnt[c];
      s_wide = {base_s[SW-1], base_s} + {{(SW + 1 - VW){in_val[c][VW-1]}}, in_val[c]};
      if (s_wide[SW] != s_wide[SW-1]) begin
        sum_next[c] = s_wide[SW] ? dga_pkg::SUM_MIN : dga_pkg::SUM_MAX;
      end else begin
        sum_next[c] = s_wide[SW-1:0];
      end
      mag = in_val[c][VW-1] ? (~{1'b1, in_val[c]} + (VW + 1)'(1)) : {1'b0, in_val[c]};
      counted = (mag > (VW + 1)'(zero_band)) && (base_n < CNT_MAX);
      cnt_next[c] = base_n + CNT_W'(counted);
    end
  end

  // a date change flushes the old group on accept; end of data flushes
  // the updated group in a later cycle once the FIFO has room
  assign q_push        = (accept && change) || (pend && !q_full);
  assign push_grp.date = gdate;
  assign push_grp.sum  = sum;
  assign push_grp.last = accept ? !rd.end_of_data : 1'b1;
  assign push_cnt      = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      open  <= 1'b0;
      pend  <= 1'b0;
      gdate <= '0;
      sum   <= '0;
      cnt   <= '0;
    end else if (accept) begin
      open  <= 1'b1;
      pend  <= rd.end_of_data;
      gdate <= in_date;
      sum   <= sum_next;
      cnt   <= cnt_next;
    end else if (pend && !q_full) begin
      open <= 1'b0;
      pend <= 1'b0;
      sum  <= '0;
      cnt  <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dga_back.sv -----
// Back end: takes closed groups from the FIFO, divides each channel sum by
// its count on one shared divider, and drives the output register.
// Uses dga_pkg, dga_out_if and dga_div.
`default_nettype none

module dga_back #(
  parameter int CNT_W = 9
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     q_empty,
  output logic                                     q_pop,
  input  dga_pkg::group_t                          pop_grp,
  input  logic [dga_pkg::CHANNELS-1:0][CNT_W-1:0]  pop_cnt,
  dga_out_if.source                                res
);

  localparam int C    = dga_pkg::CHANNELS;
  localparam int VW   = dga_pkg::VAL_W;
  localparam int SW   = dga_pkg::SUM_W;
  localparam int CH_W = (C > 1) ? $clog2(C) : 1;

  typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_OUT} state_t;

  state_t                   state;
  dga_pkg::group_t          grp;
  logic [C-1:0][CNT_W-1:0]  cnt;
  logic [CH_W-1:0]          ch;
  dga_pkg::val_t [C-1:0]    mean;
  dga_pkg::val_t            mean_ch;
  logic                     div_start;
  logic                     div_done;
  logic [SW-1:0]            dividend;
  logic [SW-1:0]            quo;
  logic                     neg;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign div_start = (state == S_START);
  assign neg       = grp.sum[ch][SW-1];
  assign dividend  = neg ? (~grp.sum[ch] + SW'(1)) : grp.sum[ch];

  dga_div #(
    .NW (SW),
    .DW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (cnt[ch]),
    .done     (div_done),
    .quotient (quo)
  );

  // truncate toward zero: divide magnitudes, restore sign, then saturate
  always_comb begin
    if (cnt[ch] == '0) begin
      mean_ch = '0;
    end else if (neg) begin
      mean_ch = (quo > dga_pkg::MEAN_NEG_LIM) ? dga_pkg::MEAN_MIN
                                              : ~quo[VW-1:0] + VW'(1);
    end else begin
      mean_ch = (quo > dga_pkg::MEAN_POS_LIM) ? dga_pkg::MEAN_MAX : quo[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      res.valid <= 1'b0;
    end else begin
      // output register loads in S_OUT once free, otherwise drops on handshake
      if ((state == S_OUT) && (!res.valid || res.ready)) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            grp   <= pop_grp;
            cnt   <= pop_cnt;
            ch    <= '0;
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            mean[ch] <= mean_ch;
            if (ch == CH_W'(C - 1)) begin
              state <= S_OUT;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_START;
            end
          end
        end
        S_OUT: begin
          if (!res.valid || res.ready) begin
            res.out_year    <= grp.date.year;
            res.out_month   <= grp.date.month;
            res.out_day     <= grp.date.day;
            res.mean_0      <= mean[0];
            res.mean_1      <= mean[1];
            res.mean_2      <= mean[2];
            res.mean_3      <= mean[3];
            res.last_of_run <= grp.last;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/daily_group_averager.sv -----
// Daily group averager, top level.
// Uses dga_pkg, dga_in_if, dga_out_if, dga_fifo, dga_front and dga_back.
//
// reading: valid/ready channel of dated readings, four signed channel values
//   in millidegrees and an end_of_data flag. An item is taken whenever valid
//   and ready are both high; the only stalls are while a flush owed by
//   end_of_data is pending and while the two-entry group FIFO is full.
// result: valid/ready channel of daily means. A result appears when a
//   reading with a new date arrives (the previous day) and after a reading
//   with end_of_data (the current day); last_of_run marks the last result
//   an item causes.
// Back end: each closed day is divided on the shared restoring divider, four
//   channels in turn, with a setup state (S_START) before each divide; the
//   next day is taken from the FIFO once the last is in the output register.
//   Readings that do not close a day wait only on the stalls above.
// Result stall: the output register holds its item until taken; the back
//   end keeps dividing the next queued day meanwhile, and the front keeps
//   accumulating until the FIFO fills.
// APB: zero_band at byte address 0, reset value 1; pready is always high.
// Reset (rst, synchronous) empties the FIFO, closes any open day and clears
//   sums and counts.
`default_nettype none

module daily_group_averager #(
  parameter int MAX_READINGS_PER_DAY = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  dga_in_if.sink                        reading,
  dga_out_if.source                     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dga_pkg::ADDR_W-1:0]    paddr,
  input  logic [dga_pkg::DATA_W-1:0]    pwdata,
  output logic [dga_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int C     = dga_pkg::CHANNELS;
  localparam int CNT_W = $clog2(MAX_READINGS_PER_DAY + 1);
  localparam int QW    = $bits(dga_pkg::group_t) + C * CNT_W;

  logic [dga_pkg::BAND_W-1:0]  zero_band;
  logic [dga_pkg::ADDR_W-3:0]  reg_idx;

  logic                        q_push;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_empty;
  dga_pkg::group_t             push_grp;
  dga_pkg::group_t             pop_grp;
  logic [C-1:0][CNT_W-1:0]     push_cnt;
  logic [C-1:0][CNT_W-1:0]     pop_cnt;
  logic [QW-1:0]               q_rdata;

  assign reg_idx = paddr[dga_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == dga_pkg::REG_ZERO_BAND) ? dga_pkg::DATA_W'(zero_band) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_band <= dga_pkg::ZERO_BAND_RESET;
    end else if (psel && penable && pwrite && (reg_idx == dga_pkg::REG_ZERO_BAND)) begin
      zero_band <= pwdata[dga_pkg::BAND_W-1:0];
    end
  end

  dga_front #(
    .MAX_READINGS_PER_DAY (MAX_READINGS_PER_DAY),
    .CNT_W                (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rd        (reading),
    .zero_band (zero_band),
    .q_full    (q_full),
    .q_push    (q_push),
    .push_grp  (push_grp),
    .push_cnt  (push_cnt)
  );

  dga_fifo #(
    .W     (QW),
    .DEPTH (2)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({push_grp, push_cnt}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {pop_grp, pop_cnt} = q_rdata;

  dga_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop_grp (pop_grp),
    .pop_cnt (pop_cnt),
    .res     (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("group FIFO written while full");

  a_eod_stalls: assert property (@(posedge clk) disable iff (rst)
    (reading.valid && reading.ready && reading.end_of_data) |=> !reading.ready)
    else $error("reading taken while end-of-data flush pending");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("group FIFO read while empty");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> q_empty)
    else $error("group FIFO not empty after reset");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for daily_group_averager: predicts the daily mean records
// that each accepted reading closes and checks the result stream in order.
// Needs rtl/dga_pkg.sv, rtl/dga_in_if.sv, rtl/dga_out_if.sv and the averager RTL.

module testbench;
  import dga_pkg::*;

  localparam int MAX_PER_DAY    = 256;
  localparam int LIMIT_CYCLES   = 2000000;
  localparam int SETTLE_CYCLES  = 160;   // a bit over one closed day in the divider
  localparam int SHOWN_ERRORS   = 10;
  localparam int VAL_TOP        = 131071;
  localparam int VAL_BOTTOM     = -131072;
  localparam int LONG_DAY_ITEMS = 520;   // enough full-scale readings to pin the sums
  localparam logic [BAND_W-1:0] BAND_AT_RESET = 10'd1;

  localparam logic [ADDR_W-3:0] REG_SPARE  = 1'b1;
  localparam logic [ADDR_W-1:0] BAND_ADDR  = {REG_ZERO_BAND, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};

  typedef struct packed {
    date_t                 date;
    val_t [CHANNELS-1:0]   value;
    logic                  eod;
  } reading_t;

  typedef struct packed {
    date_t                 date;
    val_t [CHANNELS-1:0]   mean;
    logic                  last;
  } day_mean_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dga_in_if  rd_bus ();
  dga_out_if res_bus ();

  daily_group_averager #(
    .MAX_READINGS_PER_DAY(MAX_PER_DAY)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .reading(rd_bus),
    .result (res_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  reading_t  pending_readings [$];
  day_mean_t expected_days [$];

  // predictor state
  logic [BAND_W-1:0] band_now;
  bit                day_open;
  date_t             day_date;
  longint            day_sum [CHANNELS];
  int unsigned       day_count [CHANNELS];

  int          send_idle_max;
  int          recv_idle_max;
  int          send_gap;
  int          recv_gap;
  logic        reading_taken;
  logic        result_taken;
  reading_t    next_reading;
  reading_t    seen_reading;
  day_mean_t   got_mean;
  day_mean_t   want_mean;
  int unsigned errors;
  int unsigned readings_in;
  int unsigned means_out;
  int unsigned band_writes;
  int unsigned cycle_count;

  int band_plan [6] = '{0, 1000, 1, -1, 1000, 3};  // -1 picks a random band
  int send_plan [6] = '{17, 0, 17, 0, 17, 3};
  int recv_plan [6] = '{17, 0, 0, 17, 17, 17};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void flag_error(input string what);
    errors++;
    if (errors <= SHOWN_ERRORS) $display("ERROR: %s", what);
  endfunction

  function automatic string show_mean(input day_mean_t m);
    return $sformatf("%0d-%0d-%0d means %0d %0d %0d %0d last %0b",
                     m.date.year, m.date.month, m.date.day, $signed(m.mean[0]),
                     $signed(m.mean[1]), $signed(m.mean[2]), $signed(m.mean[3]), m.last);
  endfunction

  function automatic void clear_day();
    for (int c = 0; c < CHANNELS; c++) begin
      day_sum[c]   = 0;
      day_count[c] = 0;
    end
  endfunction

  function automatic day_mean_t close_day(input logic last);
    day_mean_t m;
    longint    q;
    m.date = day_date;
    m.last = last;
    for (int c = 0; c < CHANNELS; c++) begin
      q = (day_count[c] == 0) ? 0 : day_sum[c] / longint'(day_count[c]);
      if (q > longint'(MEAN_MAX)) q = longint'(MEAN_MAX);
      if (q < longint'(MEAN_MIN)) q = longint'(MEAN_MIN);
      m.mean[c] = val_t'(q);
    end
    return m;
  endfunction

  // a date change closes the open day first; end_of_data closes after adding
  function automatic void fold_reading(input reading_t r);
    longint v;
    longint mag;
    longint s;
    if (day_open && r.date != day_date) begin
      expected_days = {expected_days, close_day(!r.eod)};
      clear_day();
    end
    day_open = 1'b1;
    day_date = r.date;
    for (int c = 0; c < CHANNELS; c++) begin
      v   = longint'($signed(r.value[c]));
      mag = (v < 0) ? -v : v;
      s   = day_sum[c] + v;
      if (s > longint'(SUM_MAX)) s = longint'(SUM_MAX);
      if (s < longint'(SUM_MIN)) s = longint'(SUM_MIN);
      day_sum[c] = s;
      if (mag > longint'(band_now) && day_count[c] < MAX_PER_DAY) day_count[c]++;
    end
    if (r.eod) begin
      expected_days = {expected_days, close_day(1'b1)};
      clear_day();
      day_open = 1'b0;
    end
  endfunction

  function automatic int draw_wait(input int max_wait);
    return (max_wait == 0) ? 0 : int'($urandom_range(0, max_wait));
  endfunction

  function automatic val_t rand_value();
    int t;
    case ($urandom_range(0, 5))
      0: t = int'($urandom_range(0, 262143)) - 131072;
      1: t = int'($urandom_range(0, 2 * band_now + 4)) - int'(band_now) - 2;
      2: begin
        case ($urandom_range(0, 4))
          0: t = VAL_TOP;
          1: t = VAL_BOTTOM;
          2: t = 100000;
          3: t = -100000;
          default: t = 0;
        endcase
      end
      default: t = int'($urandom_range(0, 200000)) - 100000;
    endcase
    return val_t'(t);
  endfunction

  function automatic date_t random_date();
    date_t d;
    d.year  = YEAR_W'($urandom_range(0, 4095));
    d.month = MONTH_W'($urandom_range(0, 15));
    d.day   = DAY_W'($urandom_range(0, 31));
    return d;
  endfunction

  function automatic date_t next_date(input date_t d);
    date_t nd;
    nd = d;
    if (d.day >= 28 || d.day == 0) begin
      nd.day = 1;
      if (d.month >= 12 || d.month == 0) begin
        nd.month = 1;
        nd.year  = d.year + 1'b1;
      end else begin
        nd.month = d.month + 1'b1;
      end
    end else begin
      nd.day = d.day + 1'b1;
    end
    return nd;
  endfunction

  function automatic reading_t make_reading(input date_t d, input logic eod);
    reading_t r;
    r.date = d;
    r.eod  = eod;
    for (int c = 0; c < CHANNELS; c++) r.value[c] = rand_value();
    return r;
  endfunction

  function automatic void push_reading(input int y, input int mo, input int d, input int v0,
                                       input int v1, input int v2, input int v3,
                                       input logic eod);
    reading_t r;
    r.date.year  = YEAR_W'(y);
    r.date.month = MONTH_W'(mo);
    r.date.day   = DAY_W'(d);
    r.value[0]   = val_t'(v0);
    r.value[1]   = val_t'(v1);
    r.value[2]   = val_t'(v2);
    r.value[3]   = val_t'(v3);
    r.eod        = eod;
    pending_readings = {pending_readings, r};
  endfunction

  // runs of same-date readings; some jumps land on arbitrary, out-of-calendar dates
  task automatic queue_random_days(input int n_items);
    date_t d;
    int    left;
    int    n_day;
    logic  eod;
    d    = random_date();
    left = n_items;
    while (left > 0) begin
      n_day = $urandom_range(1, 6);
      if (n_day > left) n_day = left;
      for (int i = 0; i < n_day; i++) begin
        eod = (i == n_day - 1) && ($urandom_range(0, 7) == 0);
        pending_readings = {pending_readings, make_reading(d, eod)};
      end
      left -= n_day;
      case ($urandom_range(0, 9))
        0, 1: d = random_date();
        2: ;  // same date again: merges, or reopens after a flush
        default: d = next_date(d);
      endcase
    end
  endtask

  // full-scale day: pins channel 0 and 1 sums at both rails, saturates counts
  task automatic queue_long_day(input date_t d);
    reading_t r;
    for (int i = 0; i < LONG_DAY_ITEMS; i++) begin
      r = make_reading(d, i == LONG_DAY_ITEMS - 1);
      if (i < LONG_DAY_ITEMS - 4) begin
        r.value[0] = val_t'(VAL_TOP);
        r.value[1] = val_t'(VAL_BOTTOM);
        r.value[2] = (i % 2 == 0) ? val_t'(VAL_TOP) : val_t'(VAL_BOTTOM);
      end
      pending_readings = {pending_readings, r};
    end
  endtask

  task automatic apb_cycle(input logic wr, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_band(input int v);
    logic [DATA_W-1:0] unused;
    apb_cycle(1'b1, BAND_ADDR, DATA_W'(v), unused);
    band_now = BAND_W'(v);
    band_writes++;
  endtask

  task automatic check_band();
    logic [DATA_W-1:0] rdata;
    apb_cycle(1'b0, BAND_ADDR, '0, rdata);
    if (rdata !== DATA_W'(band_now))
      flag_error($sformatf("zero_band reads %0d, expected %0d", rdata, band_now));
  endtask

  // sender holds off until every expected result is out, then the block settles
  task automatic wait_quiet();
    while (pending_readings.size() != 0 || rd_bus.valid || expected_days.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver: one item on the bus at a time, random gap after each
  always @(negedge clk) begin
    if (rst) begin
      rd_bus.valid <= 1'b0;
    end else if (!rd_bus.valid || reading_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        rd_bus.valid <= 1'b0;
      end else if (pending_readings.size() != 0) begin
        next_reading = pending_readings.pop_front();
        rd_bus.year         <= next_reading.date.year;
        rd_bus.month        <= next_reading.date.month;
        rd_bus.day_of_month <= next_reading.date.day;
        rd_bus.value_0      <= next_reading.value[0];
        rd_bus.value_1      <= next_reading.value[1];
        rd_bus.value_2      <= next_reading.value[2];
        rd_bus.value_3      <= next_reading.value[3];
        rd_bus.end_of_data  <= next_reading.eod;
        rd_bus.valid        <= 1'b1;
        send_gap = draw_wait(send_idle_max);
      end else begin
        rd_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (result_taken) recv_gap = draw_wait(recv_idle_max);
      if (recv_gap > 0) begin
        recv_gap--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // monitor: check results first, then fold the accepted reading into the predictor
  always @(posedge clk) begin
    reading_taken <= !rst && rd_bus.valid && rd_bus.ready;
    result_taken  <= !rst && res_bus.valid && res_bus.ready;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got_mean.date.year  = res_bus.out_year;
      got_mean.date.month = res_bus.out_month;
      got_mean.date.day   = res_bus.out_day;
      got_mean.mean[0]    = res_bus.mean_0;
      got_mean.mean[1]    = res_bus.mean_1;
      got_mean.mean[2]    = res_bus.mean_2;
      got_mean.mean[3]    = res_bus.mean_3;
      got_mean.last       = res_bus.last_of_run;
      means_out++;
      if (expected_days.size() == 0) begin
        flag_error($sformatf("unexpected result %s", show_mean(got_mean)));
      end else begin
        want_mean = expected_days.pop_front();
        if (got_mean !== want_mean)
          flag_error($sformatf("result %0d\n  expected %s\n  actual   %s", means_out,
                               show_mean(want_mean), show_mean(got_mean)));
      end
    end
    if (!rst && rd_bus.valid && rd_bus.ready) begin
      seen_reading.date.year  = rd_bus.year;
      seen_reading.date.month = rd_bus.month;
      seen_reading.date.day   = rd_bus.day_of_month;
      seen_reading.value[0]   = rd_bus.value_0;
      seen_reading.value[1]   = rd_bus.value_1;
      seen_reading.value[2]   = rd_bus.value_2;
      seen_reading.value[3]   = rd_bus.value_3;
      seen_reading.eod        = rd_bus.end_of_data;
      readings_in++;
      fold_reading(seen_reading);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_days.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] scratch;
    date_t             long_date;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rd_bus.valid        = 1'b0;
    rd_bus.year         = '0;
    rd_bus.month        = '0;
    rd_bus.day_of_month = '0;
    rd_bus.value_0      = '0;
    rd_bus.value_1      = '0;
    rd_bus.value_2      = '0;
    rd_bus.value_3      = '0;
    rd_bus.end_of_data  = 1'b0;
    res_bus.ready = 1'b0;
    reading_taken = 1'b0;
    result_taken  = 1'b0;
    send_gap      = 0;
    recv_gap      = 0;
    send_idle_max = 17;
    recv_idle_max = 17;
    errors        = 0;
    readings_in   = 0;
    means_out     = 0;
    band_writes   = 0;
    cycle_count   = 0;
    band_now      = BAND_AT_RESET;
    day_open      = 1'b0;
    day_date      = '0;
    clear_day();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    check_band();

    // directed, band at reset value
    push_reading(0, 1, 1, 0, 1, -1, 2, 1'b0);          // first reading opens a day
    push_reading(0, 1, 1, VAL_TOP, VAL_BOTTOM, 100000, -100000, 1'b0);
    push_reading(4095, 15, 31, -2, 2, VAL_TOP, VAL_BOTTOM, 1'b0);
    push_reading(4095, 15, 31, 7, -7, 0, 0, 1'b1);
    push_reading(2024, 2, 29, 5, -5, 3, -3, 1'b0);      // after a flush: no result
    push_reading(2024, 3, 1, -8, 8, 0, 0, 1'b1);        // date change plus flush
    push_reading(1, 1, 1, -7, 7, -5, 5, 1'b0);
    push_reading(1, 1, 1, -8, 8, 0, 0, 1'b1);           // quotients truncate toward zero
    push_reading(0, 0, 0, 0, 0, 1, -1, 1'b1);           // nothing counted: means 0
    push_reading(2, 1, 1, 3, 3, 3, 3, 1'b0);
    push_reading(3, 1, 1, 4, 4, 4, 4, 1'b0);            // year differs only
    push_reading(3, 2, 1, 5, 5, 5, 5, 1'b0);            // month differs only
    push_reading(3, 2, 2, 6, 6, 6, 6, 1'b0);            // day left open over the write
    wait_quiet();

    write_band(1000);
    apb_cycle(1'b1, SPARE_ADDR, DATA_W'(10'h3FF), scratch);  // no such register
    check_band();
    push_reading(3, 2, 2, 1000, -1000, 1001, -1001, 1'b0);
    push_reading(3, 2, 2, VAL_TOP, VAL_BOTTOM, 0, 1000, 1'b1);
    wait_quiet();

    write_band(0);
    check_band();
    push_reading(7, 7, 7, 0, 1, -1, 0, 1'b0);
    push_reading(7, 7, 7, 0, 0, 0, 0, 1'b1);
    push_reading(4095, 15, 31, VAL_BOTTOM, VAL_BOTTOM, VAL_BOTTOM, VAL_BOTTOM, 1'b1);
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      write_band((band_plan[p] < 0) ? int'($urandom_range(0, 1000)) : band_plan[p]);
      send_idle_max = send_plan[p];
      recv_idle_max = recv_plan[p];
      queue_random_days(100);
      wait_quiet();
    end

    write_band(0);
    send_idle_max = 0;
    recv_idle_max = 0;
    long_date.year  = 12'd2030;
    long_date.month = 4'd6;
    long_date.day   = 5'd15;
    queue_long_day(long_date);
    wait_quiet();

    $display("covered %0d readings and %0d daily means across %0d zero_band writes",
             readings_in, means_out, band_writes);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
